>>> rtl/closest_point_search_macros.svh
// assertion macros for the closest point search block
// included by the top level; no other dependencies
`ifndef CLOSEST_POINT_SEARCH_MACROS_SVH
`define CLOSEST_POINT_SEARCH_MACROS_SVH
`ifndef ASSERT_OFF
`define CPS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);
`define CPS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) \
      else $error(msg);
`else
`define CPS_ASSERT(lbl, clk, rst, prop, msg)
`define CPS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

>>> rtl/cps_pkg.sv
// shared types, widths and codes for the closest point search block
// no dependencies
`default_nettype none

package cps_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int COORD_W     = 16;
   localparam int POINT_W     = 2 * COORD_W;
   localparam int MAXD_W      = 17;
   localparam int MAG_W       = COORD_W;
   localparam int SQ_W        = 2 * MAG_W;
   localparam int DIST_W      = SQ_W + 1;
   localparam int BEST_W      = 2 * MAXD_W;
   localparam int MODE_W      = 2;
   localparam int STATUS_W    = 2;
   localparam int OUT_IDX_W   = 8;

   typedef enum logic [MODE_W-1:0] {
      MODE_CLEAR = 2'd0,
      MODE_ADD   = 2'd1,
      MODE_QUERY = 2'd2
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK   = 2'd0,
      STATUS_FULL = 2'd1,
      STATUS_NONE = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SCAN  = 3'b010,
      ST_DRAIN = 3'b100
   } state_type;

   typedef logic [IDX_W-1:0] idx_type;

   typedef struct packed {
      logic              valid;
      idx_type           index;
      logic [DIST_W-1:0] sq_dist;
   } dist_result_type;

   function automatic logic [OUT_IDX_W-1:0] out_index(input idx_type idx);
      logic [IDX_W+OUT_IDX_W-1:0] ext;
      ext = {{OUT_IDX_W{1'b0}}, idx};
      return ext[OUT_IDX_W-1:0];
   endfunction

endpackage

`default_nettype wire

>>> rtl/cps_channels.sv
// valid/ready channel interfaces for request and response beats
// depends on cps_pkg
`default_nettype none

interface cps_req_if
   import cps_pkg::*;
   ();
   logic                      valid;
   logic                      ready;
   logic [MODE_W-1:0]         mode;
   logic signed [COORD_W-1:0] x_coord;
   logic signed [COORD_W-1:0] y_coord;
   logic [MAXD_W-1:0]         max_distance;

   modport source (output valid, mode, x_coord, y_coord, max_distance, input ready);
   modport sink   (input valid, mode, x_coord, y_coord, max_distance, output ready);
endinterface

interface cps_rsp_if
   import cps_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic [STATUS_W-1:0]  status;
   logic [OUT_IDX_W-1:0] point_index;

   modport source (output valid, status, point_index, input ready);
   modport sink   (input valid, status, point_index, output ready);
endinterface

`default_nettype wire

>>> rtl/cps_dist_unit.sv
// pipelined squared-distance unit shared by every table entry of a scan
// depends on cps_pkg
`default_nettype none

module cps_dist_unit
   import cps_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      in_valid,
   input  wire idx_type                   in_index,
   input  wire logic [POINT_W-1:0]        in_point,
   input  wire logic signed [COORD_W-1:0] qx,
   input  wire logic signed [COORD_W-1:0] qy,
   output dist_result_type                result,
   output logic                           busy
);

   logic signed [COORD_W:0] dx, dy;
   logic [COORD_W:0]        abs_x, abs_y;

   logic             v1_ff, v1_in;
   idx_type          idx1_ff, idx1_in;
   logic [MAG_W-1:0] magx_ff, magx_in, magy_ff, magy_in;

   logic             v2_ff, v2_in;
   idx_type          idx2_ff, idx2_in;
   logic [SQ_W-1:0]  sqx_ff, sqx_in, sqy_ff, sqy_in;

   // stage 1: differences and magnitudes
   always_comb begin
      dx      = {qx[COORD_W-1], qx} - {in_point[COORD_W-1], in_point[COORD_W-1:0]};
      dy      = {qy[COORD_W-1], qy} - {in_point[POINT_W-1], in_point[POINT_W-1:COORD_W]};
      abs_x   = dx[COORD_W] ? (~dx + 1'b1) : dx;
      abs_y   = dy[COORD_W] ? (~dy + 1'b1) : dy;
      v1_in   = in_valid;
      idx1_in = in_index;
      magx_in = abs_x[MAG_W-1:0];
      magy_in = abs_y[MAG_W-1:0];
   end

   // stage 2: squares
   always_comb begin
      v2_in   = v1_ff;
      idx2_in = idx1_ff;
      sqx_in  = magx_ff * magx_ff;
      sqy_in  = magy_ff * magy_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
      idx1_ff <= idx1_in;
      magx_ff <= magx_in;
      magy_ff <= magy_in;
      idx2_ff <= idx2_in;
      sqx_ff  <= sqx_in;
      sqy_ff  <= sqy_in;
   end

   always_comb begin
      result.valid   = v2_ff;
      result.index   = idx2_ff;
      result.sq_dist = {1'b0, sqx_ff} + {1'b0, sqy_ff};
      busy           = v1_ff | v2_ff;
   end

endmodule

`default_nettype wire

>>> rtl/closest_point_search.sv
// closest point search: clear and add answer with a response beat in the cycle after the request beat
// a query scans the table: one table read per cycle
// feeds the shared distance pipeline (read, difference, square, compare)
// the next request beat is taken in the cycle after the response beat at the earliest
// synchronous active-high reset empties the table and idles the sequencer
`default_nettype none
`include "closest_point_search_macros.svh"

module closest_point_search
   import cps_pkg::*;
(
   input wire logic   clock,
   input wire logic   reset,
   cps_req_if.sink    req_ch,
   cps_rsp_if.source  rsp_ch
);

   logic [POINT_W-1:0] point_mem [TABLE_DEPTH];

   state_type                 state_ff, state_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [CNT_W-1:0]          scan_ff, scan_in;
   logic signed [COORD_W-1:0] qx_ff, qx_in, qy_ff, qy_in;
   logic [BEST_W-1:0]         best_ff, best_in;
   idx_type                   best_idx_ff, best_idx_in;
   logic                      found_ff, found_in;
   logic                      rd_valid_ff, rd_valid_in;
   idx_type                   rd_idx_ff, rd_idx_in;
   logic [POINT_W-1:0]        rd_data_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]       rsp_status_ff, rsp_status_in;
   logic [OUT_IDX_W-1:0]      rsp_index_ff, rsp_index_in;

   logic              accept;
   logic              rd_en;
   logic              mem_we;
   logic [BEST_W-1:0] maxd_sq;
   dist_result_type   dist_res;
   logic              dist_busy;

   assign req_ch.ready       = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign accept             = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.point_index = rsp_index_ff;

   cps_dist_unit u_dist (
      .clock    (clock),
      .reset    (reset),
      .in_valid (rd_valid_ff),
      .in_index (rd_idx_ff),
      .in_point (rd_data_ff),
      .qx       (qx_ff),
      .qy       (qy_ff),
      .result   (dist_res),
      .busy     (dist_busy)
   );

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      scan_in       = scan_ff;
      qx_in         = qx_ff;
      qy_in         = qy_ff;
      best_in       = best_ff;
      best_idx_in   = best_idx_ff;
      found_in      = found_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rd_en         = 1'b0;
      mem_we        = 1'b0;
      maxd_sq       = BEST_W'(req_ch.max_distance) * BEST_W'(req_ch.max_distance);

      if (rsp_ch.valid && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_status_in = STATUS_OK;
               rsp_index_in  = '0;
               case (mode_type'(req_ch.mode))
                  MODE_CLEAR: begin
                     count_in     = '0;
                     rsp_valid_in = 1'b1;
                  end
                  MODE_ADD: begin
                     rsp_valid_in = 1'b1;
                     if (count_ff >= CNT_W'(TABLE_DEPTH)) begin
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        mem_we       = 1'b1;
                        rsp_index_in = out_index(count_ff[IDX_W-1:0]);
                        count_in     = count_ff + CNT_W'(1);
                     end
                  end
                  MODE_QUERY: begin
                     qx_in       = req_ch.x_coord;
                     qy_in       = req_ch.y_coord;
                     best_in     = maxd_sq;
                     best_idx_in = '0;
                     found_in    = 1'b0;
                     scan_in     = '0;
                     state_in    = ST_SCAN;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (scan_ff < count_ff) begin
               rd_en   = 1'b1;
               scan_in = scan_ff + CNT_W'(1);
            end else begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!rd_valid_ff && !dist_busy) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = found_ff ? STATUS_OK : STATUS_NONE;
               rsp_index_in  = found_ff ? out_index(best_idx_ff) : '0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // strict compare keeps the lowest index on ties
      if (dist_res.valid && ({1'b0, dist_res.sq_dist} < best_ff)) begin
         best_in     = {1'b0, dist_res.sq_dist};
         best_idx_in = dist_res.index;
         found_in    = 1'b1;
      end

      rd_valid_in = rd_en;
      rd_idx_in   = scan_ff[IDX_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         point_mem[count_ff[IDX_W-1:0]] <= {req_ch.y_coord, req_ch.x_coord};
      end
      if (rd_en) begin
         rd_data_ff <= point_mem[scan_ff[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      scan_ff       <= scan_in;
      qx_ff         <= qx_in;
      qy_ff         <= qy_in;
      best_ff       <= best_in;
      best_idx_ff   <= best_idx_in;
      found_ff      <= found_in;
      rd_idx_ff     <= rd_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
   end

   `CPS_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> (state_ff == ST_IDLE && !rsp_ch.valid), "reset did not idle the block")
   `CPS_ASSERT(a_ready_no_rsp, clock, reset, req_ch.ready |-> !rsp_ch.valid, "ready while a response beat is pending")
   `CPS_ASSERT(a_add_count, clock, reset, (accept && req_ch.mode == MODE_ADD && count_ff < CNT_W'(TABLE_DEPTH)) |=> count_ff == $past(count_ff) + CNT_W'(1), "add did not grow the table")
   `CPS_ASSERT(a_read_in_scan, clock, reset, rd_valid_ff |-> $past(state_ff) == ST_SCAN, "table read outside a scan")

endmodule

`default_nettype wire
